// ===== rtl/core/qs_pkg.sv =====
// Shared constants, types and the key compare function of the quicksort engine.
package qs_pkg;

   localparam int MAX_ITEMS   = 1024;
   localparam int KEY_WIDTH   = 32;
   localparam int KEY_FIELD_W = 32;
   localparam int INDEX_W     = 10;
   localparam int ADDR_W      = $clog2(MAX_ITEMS);
   localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
   localparam int CMP_W       = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
   localparam int STACK_DEPTH = 2 * MAX_ITEMS;
   localparam int STK_AW      = $clog2(STACK_DEPTH);
   localparam int SP_W        = STK_AW + 1;
   localparam int MODE_W      = 2;
   localparam int PADDR_W     = 3;
   localparam int PDATA_W     = 32;

   localparam int MODE_SIGNED_BIT = 0;
   localparam int MODE_DESC_BIT   = 1;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [PADDR_W-3:0] REG_COMPARE_MODE = '0;

   typedef struct packed {
      logic                 we;
      logic [ADDR_W-1:0]    waddr;
      logic [KEY_WIDTH-1:0] wdata;
      logic                 re;
      logic [ADDR_W-1:0]    raddr;
   } qs_kmem_req_type;

   function automatic logic qs_no_later(logic [MODE_W-1:0] mode,
                                        logic [KEY_WIDTH-1:0] a,
                                        logic [KEY_WIDTH-1:0] b);
      logic [KEY_WIDTH-1:0] ra;
      logic [KEY_WIDTH-1:0] rb;
      ra = a;
      rb = b;
      ra[KEY_WIDTH-1] = a[KEY_WIDTH-1] ^ mode[MODE_SIGNED_BIT];
      rb[KEY_WIDTH-1] = b[KEY_WIDTH-1] ^ mode[MODE_SIGNED_BIT];
      return mode[MODE_DESC_BIT] ? (ra >= rb) : (ra <= rb);
   endfunction

endpackage

// ===== rtl/core/qs_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
module qs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/qs_sorter.sv =====
// Quicksort sequencer: bound stack memory and Lomuto partitioning over the key memory.
module qs_sorter (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [qs_pkg::CNT_W-1:0]       count,
   input  logic [qs_pkg::MODE_W-1:0]      mode,
   input  logic [qs_pkg::KEY_WIDTH-1:0]   key_rdata,
   output logic                           busy,
   output qs_pkg::qs_kmem_req_type        kmem_req
);
   import qs_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_PUSH_LO, S_PUSH_HI, S_POP1, S_POP2, S_POP3, S_PIV,
      S_RD, S_CMP, S_SW1, S_SW2, S_F1, S_F2
   } state_type;

   state_type            state_ff, state_in;
   logic [SP_W-1:0]      sp_ff, sp_in;
   logic [ADDR_W-1:0]    lo_ff, lo_in, hi_ff, hi_in;
   logic [ADDR_W-1:0]    i_ff, i_in, dest_ff, dest_in;
   logic [ADDR_W-1:0]    plo_ff, plo_in, phi_ff, phi_in;
   logic                 pend_b_ff, pend_b_in;
   logic [KEY_WIDTH-1:0] pivot_ff, pivot_in, hold_ff, hold_in;

   logic                 s_we, s_re;
   logic [STK_AW-1:0]    s_waddr, s_raddr;
   logic [ADDR_W-1:0]    s_wdata, s_rdata;
   logic [SP_W-1:0]      sp_m1, sp_m2, sp_p1;
   logic                 fits;
   logic [CNT_W-1:0]     dest_p1;
   logic                 push_a, push_b;

   qs_ram #(.WIDTH(ADDR_W), .DEPTH(STACK_DEPTH)) u_stack (
      .clock (clock),
      .we    (s_we),
      .waddr (s_waddr),
      .wdata (s_wdata),
      .re    (s_re),
      .raddr (s_raddr),
      .rdata (s_rdata)
   );

   assign sp_m1   = sp_ff - SP_W'(1);
   assign sp_m2   = sp_ff - SP_W'(2);
   assign sp_p1   = sp_ff + SP_W'(1);
   assign fits    = (sp_ff + SP_W'(2)) <= SP_W'(STACK_DEPTH);
   assign dest_p1 = CNT_W'(dest_ff) + CNT_W'(1);
   assign push_a  = dest_ff > lo_ff;
   assign push_b  = dest_p1 < CNT_W'(hi_ff);
   assign busy    = (state_ff != S_IDLE);

   always_comb begin
      state_in  = state_ff;
      sp_in     = sp_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      i_in      = i_ff;
      dest_in   = dest_ff;
      plo_in    = plo_ff;
      phi_in    = phi_ff;
      pend_b_in = pend_b_ff;
      pivot_in  = pivot_ff;
      hold_in   = hold_ff;
      s_we      = 1'b0;
      s_waddr   = sp_ff[STK_AW-1:0];
      s_wdata   = plo_ff;
      s_re      = 1'b0;
      s_raddr   = sp_m1[STK_AW-1:0];
      kmem_req  = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               sp_in     = '0;
               plo_in    = '0;
               phi_in    = ADDR_W'(count - CNT_W'(1));
               pend_b_in = 1'b0;
               state_in  = S_PUSH_LO;
            end
         end
         S_PUSH_LO: begin
            if (fits) begin
               s_we     = 1'b1;
               sp_in    = sp_p1;
               state_in = S_PUSH_HI;
            end else if (pend_b_ff) begin
               plo_in    = ADDR_W'(dest_p1);
               phi_in    = hi_ff;
               pend_b_in = 1'b0;
            end else begin
               state_in = S_POP1;
            end
         end
         S_PUSH_HI: begin
            s_we    = 1'b1;
            s_wdata = phi_ff;
            sp_in   = sp_p1;
            if (pend_b_ff) begin
               plo_in    = ADDR_W'(dest_p1);
               phi_in    = hi_ff;
               pend_b_in = 1'b0;
               state_in  = S_PUSH_LO;
            end else begin
               state_in = S_POP1;
            end
         end
         S_POP1: begin
            if (sp_ff >= SP_W'(2)) begin
               s_re     = 1'b1;
               state_in = S_POP2;
            end else begin
               sp_in    = '0;
               state_in = S_IDLE;
            end
         end
         S_POP2: begin
            s_re     = 1'b1;
            s_raddr  = sp_m2[STK_AW-1:0];
            hi_in    = s_rdata;
            state_in = S_POP3;
         end
         S_POP3: begin
            lo_in = s_rdata;
            sp_in = sp_m2;
            if (CNT_W'(hi_ff) >= CNT_W'(MAX_ITEMS) || s_rdata > hi_ff) begin
               state_in = S_POP1;
            end else begin
               kmem_req.re    = 1'b1;
               kmem_req.raddr = hi_ff;
               state_in       = S_PIV;
            end
         end
         S_PIV: begin
            pivot_in = key_rdata;
            i_in     = lo_ff;
            dest_in  = lo_ff;
            state_in = S_RD;
         end
         S_RD: begin
            kmem_req.re = 1'b1;
            if (i_ff == hi_ff) begin
               kmem_req.raddr = dest_ff;
               state_in       = S_F1;
            end else begin
               kmem_req.raddr = i_ff;
               state_in       = S_CMP;
            end
         end
         S_CMP: begin
            if (qs_no_later(mode, key_rdata, pivot_ff)) begin
               if (dest_ff == i_ff) begin
                  dest_in  = dest_ff + ADDR_W'(1);
                  i_in     = i_ff + ADDR_W'(1);
                  state_in = S_RD;
               end else begin
                  kmem_req.re    = 1'b1;
                  kmem_req.raddr = dest_ff;
                  hold_in        = key_rdata;
                  state_in       = S_SW1;
               end
            end else begin
               i_in     = i_ff + ADDR_W'(1);
               state_in = S_RD;
            end
         end
         S_SW1: begin
            kmem_req.we    = 1'b1;
            kmem_req.waddr = dest_ff;
            kmem_req.wdata = hold_ff;
            hold_in        = key_rdata;
            state_in       = S_SW2;
         end
         S_SW2: begin
            kmem_req.we    = 1'b1;
            kmem_req.waddr = i_ff;
            kmem_req.wdata = hold_ff;
            dest_in        = dest_ff + ADDR_W'(1);
            i_in           = i_ff + ADDR_W'(1);
            state_in       = S_RD;
         end
         S_F1: begin
            kmem_req.we    = 1'b1;
            kmem_req.waddr = hi_ff;
            kmem_req.wdata = key_rdata;
            state_in       = S_F2;
         end
         S_F2: begin
            kmem_req.we    = 1'b1;
            kmem_req.waddr = dest_ff;
            kmem_req.wdata = pivot_ff;
            if (push_a) begin
               plo_in    = lo_ff;
               phi_in    = dest_ff - ADDR_W'(1);
               pend_b_in = push_b;
               state_in  = S_PUSH_LO;
            end else if (push_b) begin
               plo_in    = ADDR_W'(dest_p1);
               phi_in    = hi_ff;
               pend_b_in = 1'b0;
               state_in  = S_PUSH_LO;
            end else begin
               state_in = S_POP1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         sp_ff     <= '0;
         pend_b_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         sp_ff     <= sp_in;
         pend_b_ff <= pend_b_in;
      end
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      i_ff     <= i_in;
      dest_ff  <= dest_in;
      plo_ff   <= plo_in;
      phi_ff   <= phi_in;
      pivot_ff <= pivot_in;
      hold_ff  <= hold_in;
   end

endmodule

// ===== rtl/core/quicksort_engine.sv =====
// Top level of the quicksort engine: load and read channels, register port and key memory.
// Loads and reads are taken one transaction per cycle while no sort runs and no response
// is stalled; a read's result appears in the cycle after acceptance from the key memory's
// registered read port and is held until taken. A load flagged last with two or more keys
// starts the sort, and no request is taken until it ends. The sort shares the key memory
// with the load and read channels: each partition range goes through stack handling, pivot
// setup, a scan of its keys with swaps, and pivot placement. A set already in order or in
// reverse order is the slowest case. No clearing pass runs after reset.
module quicksort_engine (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_cmd,
   input  logic [qs_pkg::KEY_FIELD_W-1:0]   req_key,
   input  logic                             req_last,
   input  logic [qs_pkg::INDEX_W-1:0]       req_read_index,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [qs_pkg::KEY_FIELD_W-1:0]   rsp_sorted_key,
   output logic [qs_pkg::INDEX_W-1:0]       rsp_echo_index,
   output logic                             rsp_out_of_range,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [qs_pkg::PADDR_W-1:0]       csr_paddr,
   input  logic [qs_pkg::PDATA_W-1:0]       csr_pwdata,
   output logic [qs_pkg::PDATA_W-1:0]       csr_prdata,
   output logic                             csr_pready
);
   import qs_pkg::*;

   logic [MODE_W-1:0]    mode_ff, mode_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 set_closed_ff, set_closed_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]   rsp_index_ff;
   logic                 rsp_oor_ff;

   logic                 load_acc, read_acc, room, sort_start, sort_busy, mode_sel;
   logic [CNT_W-1:0]     base;
   logic [KEY_WIDTH-1:0] key_rdata;
   qs_kmem_req_type      host_req, sort_req, kmem_req;

   assign csr_pready = 1'b1;
   assign mode_sel   = (csr_paddr[PADDR_W-1:2] == REG_COMPARE_MODE);
   assign mode_in    = (csr_psel && csr_penable && csr_pwrite && mode_sel) ?
                       csr_pwdata[MODE_W-1:0] : mode_ff;
   assign csr_prdata = mode_sel ? PDATA_W'(mode_ff) : '0;

   assign req_ready = !sort_busy && (!rsp_valid_ff || rsp_ready);
   assign load_acc  = req_valid && req_ready && (req_cmd == CMD_LOAD);
   assign read_acc  = req_valid && req_ready && (req_cmd == CMD_READ);

   assign base          = set_closed_ff ? '0 : count_ff;
   assign room          = base < CNT_W'(MAX_ITEMS);
   assign count_in      = load_acc ? (room ? base + CNT_W'(1) : base) : count_ff;
   assign set_closed_in = load_acc ? req_last : set_closed_ff;
   assign sort_start    = load_acc && req_last && (count_in > CNT_W'(1));
   assign rsp_valid_in  = read_acc || (rsp_valid_ff && !rsp_ready);

   always_comb begin
      host_req       = '0;
      host_req.we    = load_acc && room;
      host_req.waddr = ADDR_W'(base);
      host_req.wdata = KEY_WIDTH'(req_key);
      host_req.re    = read_acc;
      host_req.raddr = ADDR_W'(req_read_index);
      kmem_req       = sort_busy ? sort_req : host_req;
   end

   qs_ram #(.WIDTH(KEY_WIDTH), .DEPTH(MAX_ITEMS)) u_keys (
      .clock (clock),
      .we    (kmem_req.we),
      .waddr (kmem_req.waddr),
      .wdata (kmem_req.wdata),
      .re    (kmem_req.re),
      .raddr (kmem_req.raddr),
      .rdata (key_rdata)
   );

   qs_sorter u_sorter (
      .clock     (clock),
      .reset     (reset),
      .start     (sort_start),
      .count     (count_in),
      .mode      (mode_ff),
      .key_rdata (key_rdata),
      .busy      (sort_busy),
      .kmem_req  (sort_req)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= '0;
         count_ff      <= '0;
         set_closed_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         count_ff      <= count_in;
         set_closed_ff <= set_closed_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      if (read_acc) begin
         rsp_index_ff <= req_read_index;
         rsp_oor_ff   <= !(CMP_W'(req_read_index) < CMP_W'(count_ff));
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_echo_index   = rsp_index_ff;
   assign rsp_out_of_range = rsp_oor_ff;
   assign rsp_sorted_key   = rsp_oor_ff ? '0 : KEY_FIELD_W'(key_rdata);

endmodule

// ===== rtl/core/qs_checker.sv =====
// Port-level assertions for the quicksort engine and the bind that attaches them.
module qs_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             req_cmd,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [qs_pkg::KEY_FIELD_W-1:0]   rsp_sorted_key,
   input logic [qs_pkg::INDEX_W-1:0]       rsp_echo_index,
   input logic                             rsp_out_of_range,
   input logic                             csr_pready
);
   import qs_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sorted_key)
         && $stable(rsp_echo_index) && $stable(rsp_out_of_range))
      else $error("stalled response changed");

   a_read_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_cmd == CMD_READ) |=> rsp_valid)
      else $error("read transaction gave no response");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while response stalled");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> (rsp_sorted_key == '0))
      else $error("out of range response with nonzero key");

   a_pready: assert property (@(posedge clock) disable iff (reset)
      csr_pready)
      else $error("register port not ready");

endmodule

bind quicksort_engine qs_checker u_qs_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_cmd          (req_cmd),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_sorted_key   (rsp_sorted_key),
   .rsp_echo_index   (rsp_echo_index),
   .rsp_out_of_range (rsp_out_of_range),
   .csr_pready       (csr_pready)
);

// ===== sim/testbench.sv =====
// Self-checking testbench for the quicksort engine: loads, sorts and reads against a predictor.
`timescale 1ns / 1ps

module testbench;
   import qs_pkg::*;

   localparam int unsigned PERIOD_NS   = 20;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned PHASE_ITEMS = 30;
   localparam longint unsigned TIMEOUT_NS = 80_000_000;

   typedef struct {
      logic [KEY_FIELD_W-1:0] key;
      logic [INDEX_W-1:0]     index;
      logic                   out_of_range;
   } read_result_type;

   class sorted_key_scoreboard_type;
      logic [KEY_WIDTH-1:0] store [MAX_ITEMS];
      int unsigned          held;
      bit                   set_sorted;
      logic [MODE_W-1:0]    mode;
      read_result_type      pending_reads[$];
      int                   mismatches;

      function new();
         held       = 0;
         set_sorted = 1'b0;
         mode       = '0;
         mismatches = 0;
      endfunction

      function bit in_order(logic [KEY_WIDTH-1:0] a, logic [KEY_WIDTH-1:0] b);
         logic [KEY_WIDTH-1:0] rank_a;
         logic [KEY_WIDTH-1:0] rank_b;
         rank_a = a;
         rank_b = b;
         if (mode[MODE_SIGNED_BIT]) begin
            rank_a[KEY_WIDTH-1] = ~rank_a[KEY_WIDTH-1];
            rank_b[KEY_WIDTH-1] = ~rank_b[KEY_WIDTH-1];
         end
         if (mode[MODE_DESC_BIT])
            return rank_a >= rank_b;
         return rank_a <= rank_b;
      endfunction

      function void sort_store();
         int unsigned          span_lo[$];
         int unsigned          span_hi[$];
         int unsigned          lo;
         int unsigned          hi;
         int unsigned          dest;
         int unsigned          i;
         logic [KEY_WIDTH-1:0] pivot;
         logic [KEY_WIDTH-1:0] spare;
         if (held <= 1)
            return;
         span_lo.push_back(0);
         span_hi.push_back(held - 1);
         while (span_lo.size() != 0) begin
            lo    = span_lo.pop_back();
            hi    = span_hi.pop_back();
            pivot = store[hi];
            dest  = lo;
            for (i = lo; i < hi; i++) begin
               if (in_order(store[i], pivot)) begin
                  spare       = store[dest];
                  store[dest] = store[i];
                  store[i]    = spare;
                  dest++;
               end
            end
            spare       = store[hi];
            store[hi]   = store[dest];
            store[dest] = spare;
            if (dest > lo) begin
               span_lo.push_back(lo);
               span_hi.push_back(dest - 1);
            end
            if (dest + 1 < hi) begin
               span_lo.push_back(dest + 1);
               span_hi.push_back(hi);
            end
         end
      endfunction

      function void note_request(logic cmd, logic [KEY_FIELD_W-1:0] key, logic last,
                                 logic [INDEX_W-1:0] index);
         read_result_type r;
         if (cmd == CMD_LOAD) begin
            if (set_sorted) begin
               set_sorted = 1'b0;
               held       = 0;
            end
            if (held < MAX_ITEMS) begin
               store[held] = key[KEY_WIDTH-1:0];
               held++;
            end
            if (last) begin
               sort_store();
               set_sorted = 1'b1;
            end
         end else begin
            r.index = index;
            if (index < held) begin
               r.key          = store[index];
               r.out_of_range = 1'b0;
            end else begin
               r.key          = '0;
               r.out_of_range = 1'b1;
            end
            pending_reads.push_back(r);
         end
      endfunction

      function void check_read_result(logic [KEY_FIELD_W-1:0] key, logic [INDEX_W-1:0] index,
                                      logic out_of_range);
         read_result_type r;
         if (pending_reads.size() == 0) begin
            $error("unexpected read result: sorted_key %h echo_index %0d", key, index);
            mismatches++;
            return;
         end
         r = pending_reads.pop_front();
         if (key !== r.key) begin
            $error("sorted_key: expected %h, actual %h", r.key, key);
            mismatches++;
         end
         if (index !== r.index) begin
            $error("echo_index: expected %0d, actual %0d", r.index, index);
            mismatches++;
         end
         if (out_of_range !== r.out_of_range) begin
            $error("out_of_range: expected %b, actual %b", r.out_of_range, out_of_range);
            mismatches++;
         end
      endfunction

      function int outstanding();
         return pending_reads.size();
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic                   req_cmd;
   logic [KEY_FIELD_W-1:0] req_key;
   logic                   req_last;
   logic [INDEX_W-1:0]     req_read_index;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [KEY_FIELD_W-1:0] rsp_sorted_key;
   logic [INDEX_W-1:0]     rsp_echo_index;
   logic                   rsp_out_of_range;
   logic                   csr_psel;
   logic                   csr_penable;
   logic                   csr_pwrite;
   logic [PADDR_W-1:0]     csr_paddr;
   logic [PDATA_W-1:0]     csr_pwdata;
   logic [PDATA_W-1:0]     csr_prdata;
   logic                   csr_pready;

   sorted_key_scoreboard_type sb = new();
   int unsigned items_sent;
   int unsigned idle_pct;
   int unsigned stall_pct;
   int unsigned hold_asked;
   int          csr_mismatches;

   quicksort_engine DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_key          (req_key),
      .req_last         (req_last),
      .req_read_index   (req_read_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sorted_key   (rsp_sorted_key),
      .rsp_echo_index   (rsp_echo_index),
      .rsp_out_of_range (rsp_out_of_range),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #(PERIOD_NS / 2) clock = ~clock;
   end

   initial begin
      int unsigned hold_taken;
      int unsigned hold_left;
      hold_taken = 0;
      hold_left  = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            sb.check_read_result(rsp_sorted_key, rsp_echo_index, rsp_out_of_range);
         if (hold_asked != hold_taken) begin
            hold_taken = hold_asked;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   task automatic send_req(input logic cmd, input logic [KEY_FIELD_W-1:0] key,
                           input logic last, input logic [INDEX_W-1:0] index);
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_key        <= key;
      req_last       <= last;
      req_read_index <= index;
      do @(posedge clock); while (!req_ready);
      sb.note_request(cmd, key, last, index);
      items_sent++;
   endtask

   task automatic send_load(input logic [KEY_FIELD_W-1:0] key, input logic last);
      send_req(CMD_LOAD, key, last, INDEX_W'($urandom));
   endtask

   task automatic send_read(input logic [INDEX_W-1:0] index);
      send_req(CMD_READ, $urandom, 1'($urandom), index);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
   endtask

   task automatic csr_access(input logic write, input logic [PADDR_W-1:0] addr,
                             input logic [PDATA_W-1:0] wdata, output logic [PDATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_compare_mode();
      logic [PDATA_W-1:0] value;
      csr_access(1'b0, {REG_COMPARE_MODE, 2'b00}, '0, value);
      if (value !== PDATA_W'(sb.mode)) begin
         $error("compare_mode: expected %0d, actual %0d", sb.mode, value);
         csr_mismatches++;
      end
   endtask

   // The block is idle here: every set ends with a read, which waits for the sort.
   task automatic set_compare_mode(input logic [MODE_W-1:0] mode);
      logic [PDATA_W-1:0] unused;
      drain_results();
      csr_access(1'b1, {REG_COMPARE_MODE, 2'b00}, PDATA_W'(mode), unused);
      sb.mode = mode;
      check_compare_mode();
   endtask

   task automatic random_set();
      int unsigned            n;
      int unsigned            pattern;
      int unsigned            reads;
      int unsigned            i;
      int unsigned            pick;
      logic [KEY_FIELD_W-1:0] base;
      logic [KEY_FIELD_W-1:0] stride;
      logic [KEY_FIELD_W-1:0] k;
      pattern = $urandom_range(4);
      if (pattern == 0)
         n = ($urandom_range(7) == 0) ? $urandom_range(64, 200) : $urandom_range(2, 40);
      else
         n = $urandom_range(1, 48);
      base   = $urandom;
      stride = $urandom_range(1, 1 << 20);
      for (i = 0; i < n; i++) begin
         if ($urandom_range(11) == 0)
            send_read(INDEX_W'($urandom));
         case (pattern)
            0: k = $urandom;
            1: k = base + i * stride;
            2: k = base - i * stride;
            3: begin
               case ($urandom_range(4))
                  0: k = 32'h0000_0000;
                  1: k = 32'h7FFF_FFFF;
                  2: k = 32'h8000_0000;
                  3: k = 32'hFFFF_FFFF;
                  default: k = $urandom_range(3);
               endcase
            end
            default: k = $urandom_range(16) - 8;
         endcase
         send_load(k, i == n - 1);
      end
      reads = $urandom_range(1, n + 2);
      for (i = 0; i < reads; i++) begin
         pick = $urandom_range(9);
         if (pick < 8)
            send_read(INDEX_W'($urandom_range(n - 1)));
         else if (pick == 8)
            send_read(INDEX_W'($urandom));
         else
            send_read(INDEX_W'(n));
      end
   endtask

   initial begin
      int unsigned p;
      int unsigned m;
      int unsigned i;
      int unsigned goal;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_cmd        = CMD_LOAD;
      req_key        = '0;
      req_last       = 1'b0;
      req_read_index = '0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      items_sent     = 0;
      idle_pct       = 0;
      stall_pct      = 0;
      hold_asked     = 0;
      csr_mismatches = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      check_compare_mode();
      send_read('0);
      send_read('1);
      send_load(32'hFFFF_FFFF, 1'b1);
      send_read(INDEX_W'(0));
      send_read(INDEX_W'(1));
      send_load(32'h8000_0000, 1'b0);
      send_load(32'h7FFF_FFFF, 1'b0);
      send_read(INDEX_W'(1));
      send_load(32'h0000_0000, 1'b0);
      send_load(32'hFFFF_FFFF, 1'b0);
      send_load(32'h0000_0001, 1'b1);
      for (i = 0; i <= 5; i++)
         send_read(INDEX_W'(i));
      set_compare_mode(2'd3);
      send_read(INDEX_W'(0));
      send_read(INDEX_W'(4));
      send_load(32'h0000_0001, 1'b0);
      send_load(32'hFFFF_FFFF, 1'b0);
      send_load(32'h8000_0000, 1'b1);
      send_read(INDEX_W'(0));
      send_read(INDEX_W'(2));

      for (p = 0; p < 4; p++) begin
         for (m = 0; m < 4; m++) begin
            case (p)
               0: begin idle_pct = 0;  stall_pct = 0;  end
               1: begin idle_pct = 47; stall_pct = 0;  end
               2: begin idle_pct = 0;  stall_pct = 47; end
               default: begin idle_pct = 27; stall_pct = 27; end
            endcase
            set_compare_mode(MODE_W'((p + m) % 4));
            if (p == 2 && m == 0) begin
               hold_asked++;
               for (i = 0; i < 24; i++)
                  send_read(INDEX_W'($urandom));
            end
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal) begin
               random_set();
               if ($urandom_range(5) == 0)
                  drain_results();
            end
         end
      end

      drain_results();
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && csr_mismatches == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("testbench: FAIL");
      $finish;
   end

endmodule
